### hw/rtl/tccs_pkg.sv
// Shared types and constants for the text console cursor/scroll block.
`timescale 1ns / 1ps

package tccs_pkg;

  // Default store geometry
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;

  // Port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;
  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST    = 7'd48;

  // Item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Byte codes
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CURSOR = 8'h5F;

  // Input payload, last field in the low bits
  typedef struct packed {
    logic [5:0] read_row;
    logic [6:0] read_column;
    logic [7:0] character;
  } in_req_t;

  // Result payload, last field in the low bits
  typedef struct packed {
    logic [7:0] cell_value;
    logic       cleared;
    logic       scrolled;
    logic [5:0] cursor_row;
    logic [6:0] cursor_column;
  } out_res_t;

  localparam int IN_REQ_W  = $bits(in_req_t);
  localparam int OUT_RES_W = $bits(out_res_t);

endpackage

### hw/rtl/tccs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tccs_ctrl.sv
// Sequencer: cursor update, scroll copy, clear sweep and cell reads over the screen RAM.
`timescale 1ns / 1ps

module tccs_ctrl #(
  parameter int MAX_COLUMNS = tccs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tccs_pkg::DEF_MAX_ROWS,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int AW = CW + RW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CW-1:0]      nc_m1,
  input  logic [RW-1:0]      nr_m1,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  tccs_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output tccs_pkg::out_res_t out_res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [7:0]         mem_rdata
);

  import tccs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PUT, S_SCROLL, S_DRAIN, S_BLANK, S_CURS, S_RDWAIT, S_RESP
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_line_r, cur_line_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          scr_r, scr_nxt;
  logic          clr_r, clr_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [7:0]    cell_r, cell_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [RW-1:0] sc_row_r, sc_row_nxt;
  logic [CW-1:0] sc_col_r, sc_col_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_res_t      out_res_r, out_res_nxt;

  logic [8:0]    rcx;
  logic [7:0]    rrx;
  logic [8:0]    ocx;
  logic [7:0]    orx;
  logic [RW-1:0] sc_row_p1;
  logic          is_ctrl;

  assign rcx       = 9'(in_req.read_column);
  assign rrx       = 8'(in_req.read_row);
  assign ocx       = 9'(cur_col_r);
  assign orx       = 8'(cur_line_r);
  assign sc_row_p1 = sc_row_r + RW'(1);
  assign is_ctrl   = (ch_r == CH_LF) || (ch_r == CH_CR) || (ch_r == CH_FF) || (ch_r == CH_BS);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // RAM port selection; a pending scroll write-back has the write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_line_r, cur_col_r};
    mem_wdata = CH_SPACE;
    mem_raddr = {rrx[RW-1:0], rcx[CW-1:0]};
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = is_ctrl ? CH_SPACE : ch_r;
      end
      S_SCROLL: mem_raddr = {sc_row_p1, sc_col_r};
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {nr_m1, sc_col_r};
      end
      S_CURS: begin
        mem_we    = 1'b1;
        mem_wdata = CH_CURSOR;
      end
      default: ;
    endcase
    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = mem_rdata;
    end
  end

  always_comb begin
    logic down;
    down          = 1'b0;
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_line_nxt  = cur_line_r;
    ch_nxt        = ch_r;
    scr_nxt       = scr_r;
    clr_nxt       = clr_r;
    rd_ok_nxt     = rd_ok_r;
    cell_nxt      = cell_r;
    clr_cnt_nxt   = clr_cnt_r;
    sc_row_nxt    = sc_row_r;
    sc_col_nxt    = sc_col_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == '1) begin
          cur_col_nxt  = '0;
          cur_line_nxt = '0;
          state_nxt    = clr_r ? S_CURS : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          scr_nxt = 1'b0;
          clr_nxt = 1'b0;
          if (in_kind == KIND_READ) begin
            rd_ok_nxt = (rcx <= 9'(nc_m1)) && (rrx <= 8'(nr_m1));
            state_nxt = S_RDWAIT;
          end else begin
            // clamp a cursor left outside the area by a geometry change
            cur_col_nxt  = (cur_col_r > nc_m1) ? nc_m1 : cur_col_r;
            cur_line_nxt = (cur_line_r > nr_m1) ? nr_m1 : cur_line_r;
            ch_nxt       = in_req.character;
            cell_nxt     = '0;
            state_nxt    = S_PUT;
          end
        end
      end
      S_PUT: begin
        state_nxt = S_CURS;
        priority if (ch_r == CH_LF || ch_r == CH_CR) begin
          cur_col_nxt = '0;
          down        = 1'b1;
        end else if (ch_r == CH_FF) begin
          clr_nxt     = 1'b1;
          clr_cnt_nxt = '0;
          state_nxt   = S_CLEAR;
        end else if (ch_r == CH_BS) begin
          priority if (cur_col_r != '0) begin
            cur_col_nxt = cur_col_r - CW'(1);
          end else if (cur_line_r != '0) begin
            cur_col_nxt  = nc_m1;
            cur_line_nxt = cur_line_r - RW'(1);
          end else begin
            cur_col_nxt = '0;
          end
        end else begin
          if (cur_col_r == nc_m1) begin
            cur_col_nxt = '0;
            down        = 1'b1;
          end else begin
            cur_col_nxt = cur_col_r + CW'(1);
          end
        end
        if (down) begin
          if (cur_line_r == nr_m1) begin
            scr_nxt    = 1'b1;
            sc_row_nxt = '0;
            sc_col_nxt = '0;
            state_nxt  = (nr_m1 == '0) ? S_BLANK : S_SCROLL;
          end else begin
            cur_line_nxt = cur_line_r + RW'(1);
          end
        end
      end
      S_SCROLL: begin
        // read row r+1 now, write it to row r next cycle
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = {sc_row_r, sc_col_r};
        if (sc_col_r == nc_m1) begin
          sc_col_nxt = '0;
          if (sc_row_p1 == nr_m1) begin
            state_nxt = S_DRAIN;
          end else begin
            sc_row_nxt = sc_row_p1;
          end
        end else begin
          sc_col_nxt = sc_col_r + CW'(1);
        end
      end
      S_DRAIN: state_nxt = S_BLANK;
      S_BLANK: begin
        if (sc_col_r == nc_m1) begin
          cur_col_nxt  = '0;
          cur_line_nxt = nr_m1;
          state_nxt    = S_CURS;
        end else begin
          sc_col_nxt = sc_col_r + CW'(1);
        end
      end
      S_CURS: state_nxt = S_RESP;
      S_RDWAIT: begin
        cell_nxt  = rd_ok_r ? mem_rdata : 8'h00;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_res_nxt.cursor_column = ocx[6:0];
          out_res_nxt.cursor_row    = orx[5:0];
          out_res_nxt.scrolled      = scr_r;
          out_res_nxt.cleared       = clr_r;
          out_res_nxt.cell_value    = cell_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_col_r   <= '0;
      cur_line_r  <= '0;
      scr_r       <= 1'b0;
      clr_r       <= 1'b0;
      clr_cnt_r   <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_line_r  <= cur_line_nxt;
      scr_r       <= scr_nxt;
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r      <= ch_nxt;
    rd_ok_r   <= rd_ok_nxt;
    cell_r    <= cell_nxt;
    sc_row_r  <= sc_row_nxt;
    sc_col_r  <= sc_col_nxt;
    wr_addr_r <= wr_addr_nxt;
    out_res_r <= out_res_nxt;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start work");

  a_writeback_follows_scroll_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> $past(state_r == S_SCROLL))
    else $error("scroll write-back without a preceding read");

  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !clr_r && !scr_r && cell_r == 8'h00 && !rd_ok_r)
      |-> (cur_col_r <= nc_m1 || cur_line_r <= nr_m1 || !$past(state_r == S_CURS)))
    else $error("cursor outside the area after a put");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |-> !(scr_r && clr_r))
    else $error("scroll and clear reported for one put");

endmodule

### hw/rtl/text_console_cursor_scroll.sv
// Top level: text console character store with cursor, scroll and clear.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser kind; tdata character, read_column, read_row
//  out_    | out | out_tvalid/out_tready| tdata cursor_column, cursor_row, scrolled, cleared,
//          |     |                      |   cell_value
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata (columns, rows)
//
// A read passes through the RDWAIT and RESP states and an ordinary put through PUT, CURS
// and RESP, one screen RAM access per cycle; out_tvalid is registered from RESP. A scroll
// copies rows 1 to rows-1 up by one row, one copied cell per cycle through the RAM read
// port, then blanks the bottom row (only the blank when rows is 1); a form feed sweeps all
// 2**clog2(MAX_ROWS) * 2**clog2(MAX_COLUMNS) cells of the RAM (8192 at default size).
// After reset the same sweep runs with in_tready low; cfg writes are taken meanwhile.
// A result waiting on out_tready does not block acceptance of the next transaction;
// that transaction's result holds until the output register is free.
`timescale 1ns / 1ps

module text_console_cursor_scroll #(
  parameter int MAX_COLUMNS = tccs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tccs_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] character, [14:8] read_column, [20:15] read_row, [23:21] zero
  input  logic [tccs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] cursor_column, [12:7] cursor_row, [13] scrolled, [14] cleared,
  // [22:15] cell_value, [23] zero
  output logic [tccs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import tccs_pkg::*;

  localparam int CW        = $clog2(MAX_COLUMNS);
  localparam int RW        = $clog2(MAX_ROWS);
  localparam int AW        = CW + RW;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_RES_W;

  logic [7:0]    columns_r;
  logic [6:0]    rows_r;
  logic [8:0]    ncx, nc_m1_x;
  logic [7:0]    nrx, nr_m1_x;
  logic [CW-1:0] nc_m1;
  logic [RW-1:0] nr_m1;
  in_req_t       in_req;
  out_res_t      out_res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: columns_r <= cfg_wdata;
        CFG_ROWS:    rows_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // geometry in use: zero acts as one, oversize acts as the store size
  always_comb begin
    priority if (columns_r == '0)                ncx = 9'd1;
    else if (9'(columns_r) > 9'(MAX_COLUMNS))    ncx = 9'(MAX_COLUMNS);
    else                                         ncx = 9'(columns_r);
    priority if (rows_r == '0)                   nrx = 8'd1;
    else if (8'(rows_r) > 8'(MAX_ROWS))          nrx = 8'(MAX_ROWS);
    else                                         nrx = 8'(rows_r);
  end

  assign nc_m1_x = ncx - 9'd1;
  assign nr_m1_x = nrx - 8'd1;
  assign nc_m1   = nc_m1_x[CW-1:0];
  assign nr_m1   = nr_m1_x[RW-1:0];

  assign in_req    = in_req_t'(in_tdata[IN_REQ_W-1:0]);
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res};

  tccs_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .nc_m1     (nc_m1),
    .nr_m1     (nr_m1),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser[0]),
    .in_req    (in_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tccs_ram #(
    .WIDTH (8),
    .DEPTH (1 << AW)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### verif/tccs_checker.sv
// Checker for the text console block: predicts each report and compares it.
`timescale 1ns / 1ps

module tccs_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tccs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [0:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tccs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               mismatches,
  output int                               pending
);

  import tccs_pkg::*;

  localparam int NCOL = DEF_MAX_COLUMNS;
  localparam int NROW = DEF_MAX_ROWS;

  logic [7:0] screen [NROW][NCOL];
  logic [6:0] cur_col;
  logic [5:0] cur_row;
  logic [7:0] reg_columns;
  logic [6:0] reg_rows;
  out_res_t   pending_reports [$];
  int         fail_total;

  function automatic void blank_screen();
    int r;
    int c;
    for (r = 0; r < NROW; r++)
      for (c = 0; c < NCOL; c++)
        screen[r][c] = CH_SPACE;
  endfunction

  // Advances the shadow console by one transaction and returns its report.
  function automatic out_res_t console_predict(input logic kind, input in_req_t req);
    out_res_t    res;
    int unsigned nc;
    int unsigned nr;
    int unsigned col;
    int unsigned row;
    int unsigned r;
    int unsigned c;
    bit          down;
    res = '0;
    nc = (reg_columns == 0) ? 1 : ((reg_columns > NCOL) ? NCOL : reg_columns);
    nr = (reg_rows == 0) ? 1 : ((reg_rows > NROW) ? NROW : reg_rows);
    if (kind == KIND_READ) begin
      if (req.read_column < nc && req.read_row < nr)
        res.cell_value = screen[req.read_row][req.read_column];
    end else begin
      // cursor may sit outside the area after a geometry change
      if (cur_col >= nc) cur_col = 7'(nc - 1);
      if (cur_row >= nr) cur_row = 6'(nr - 1);
      col  = cur_col;
      row  = cur_row;
      down = 1'b0;
      screen[row][col] = CH_SPACE;
      if (req.character == CH_LF || req.character == CH_CR) begin
        col  = 0;
        down = 1'b1;
      end else if (req.character == CH_FF) begin
        blank_screen();
        col = 0;
        row = 0;
        res.cleared = 1'b1;
      end else if (req.character == CH_BS) begin
        if (col > 0) begin
          col--;
        end else if (row > 0) begin
          col = nc - 1;
          row--;
        end
      end else begin
        screen[row][col] = req.character;
        col++;
        if (col >= nc) begin
          col  = 0;
          down = 1'b1;
        end
      end
      if (down) begin
        if (row + 1 >= nr) begin
          // only the columns in use move up
          for (r = 0; r + 1 < nr; r++)
            for (c = 0; c < nc; c++)
              screen[r][c] = screen[r + 1][c];
          for (c = 0; c < nc; c++)
            screen[nr - 1][c] = CH_SPACE;
          col = 0;
          row = nr - 1;
          res.scrolled = 1'b1;
        end else begin
          row++;
        end
      end
      screen[row][col] = CH_CURSOR;
      cur_col = 7'(col);
      cur_row = 6'(row);
    end
    res.cursor_column = cur_col;
    res.cursor_row    = cur_row;
    return res;
  endfunction

  always @(posedge clk) begin
    out_res_t got;
    out_res_t want;
    if (!rst_n) begin
      blank_screen();
      cur_col     = '0;
      cur_row     = '0;
      reg_columns = COLUMNS_RST;
      reg_rows    = ROWS_RST;
      pending_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COLUMNS) reg_columns = cfg_wdata[7:0];
        else if (cfg_index == CFG_ROWS) reg_rows = cfg_wdata[6:0];
      end
      // retire before predicting: a report never leaves in its own acceptance cycle
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_RES_W-1:0];
        if (pending_reports.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: extra report col=%0d row=%0d scr=%0b clr=%0b cell=%02h",
                     $time, got.cursor_column, got.cursor_row, got.scrolled, got.cleared,
                     got.cell_value);
          fail_total++;
        end else begin
          want = pending_reports.pop_front();
          if (got.cursor_column !== want.cursor_column || got.cursor_row !== want.cursor_row ||
              got.scrolled !== want.scrolled || got.cleared !== want.cleared ||
              got.cell_value !== want.cell_value) begin
            if (fail_total < 10)
              $display("%0t: mismatch exp %0d,%0d,%0b,%0b,%02h got %0d,%0d,%0b,%0b,%02h",
                       $time, want.cursor_column, want.cursor_row, want.scrolled,
                       want.cleared, want.cell_value, got.cursor_column, got.cursor_row,
                       got.scrolled, got.cleared, got.cell_value);
            fail_total++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_reports.push_back(console_predict(in_tuser[0], in_tdata[IN_REQ_W-1:0]));
    end
    mismatches <= fail_total;
    pending    <= pending_reports.size();
  end

endmodule

### verif/tb_text_console_cursor_scroll.sv
// Testbench top for the text console block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
  import tccs_pkg::*;

  localparam int NPHASE = 12;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     mismatches;
  int                     pending;

  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 65;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // geometry and transaction count of each random phase
  int unsigned phase_cols  [NPHASE] = '{8, 3, 1, 200, 0, 16, 128, 5, 80, 12, 2, 255};
  int unsigned phase_rows  [NPHASE] = '{4, 2, 127, 1, 0, 8, 64, 3, 48, 6, 64, 127};
  int unsigned phase_items [NPHASE] = '{200, 120, 130, 100, 80, 150, 60, 150, 100, 150, 100, 40};

  text_console_cursor_scroll dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tccs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen  <= hold_reqs;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] ch, input logic [6:0] col,
                           input logic [5:0] row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, row, col, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [7:0] cols, input logic [6:0] rws);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= {1'b0, rws};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #400_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned nc;
    int unsigned nr;
    int unsigned pick;
    logic [7:0]  ch;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // default geometry 80x48; a read before any put sees a space
    send_item(KIND_READ, 8'h00, 7'd0, 6'd0);
    send_item(KIND_PUT, 8'h41, 7'd0, 6'd0);
    send_item(KIND_PUT, 8'h00, 7'd0, 6'd0);
    send_item(KIND_PUT, 8'hFF, 7'd0, 6'd0);
    send_item(KIND_PUT, 8'h09, 7'd0, 6'd0);
    send_item(KIND_PUT, CH_CR, 7'd0, 6'd0);
    send_item(KIND_PUT, CH_LF, 7'd0, 6'd0);
    send_item(KIND_PUT, CH_BS, 7'd0, 6'd0);     // wraps to the end of the row above
    send_item(KIND_READ, 8'h00, 7'd79, 6'd1);
    send_item(KIND_READ, 8'hFF, 7'd0, 6'd0);
    send_item(KIND_READ, 8'h00, 7'd127, 6'd63);
    send_item(KIND_READ, 8'h00, 7'd80, 6'd0);
    send_item(KIND_READ, 8'h00, 7'd0, 6'd48);
    send_item(KIND_READ, 8'h00, 7'd79, 6'd47);
    send_item(KIND_PUT, CH_FF, 7'd0, 6'd0);
    send_item(KIND_PUT, CH_BS, 7'd0, 6'd0);     // backspace at home stays home
    send_item(KIND_READ, 8'h00, 7'd0, 6'd0);
    send_item(KIND_PUT, 8'h42, 7'd0, 6'd0);
    wait_idle();

    // zero registers act as a 1x1 screen; cursor at column 1 is now outside it
    write_geometry(8'd0, 7'd0);
    send_item(KIND_READ, 8'h00, 7'd0, 6'd0);
    send_item(KIND_PUT, 8'h78, 7'd0, 6'd0);
    send_item(KIND_PUT, CH_LF, 7'd0, 6'd0);
    send_item(KIND_PUT, CH_BS, 7'd0, 6'd0);
    send_item(KIND_READ, 8'h00, 7'd1, 6'd0);
    wait_idle();

    // registers above the store size clamp to it
    write_geometry(8'd255, 7'd127);
    send_item(KIND_PUT, 8'h7E, 7'd0, 6'd0);
    send_item(KIND_READ, 8'h00, 7'd127, 6'd63);
    wait_idle();

    for (p = 0; p < NPHASE; p++) begin
      if (p == 4) begin
        tx_idle_pct <= 65;
        rx_idle_pct <= 15;
      end else if (p == 8) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      write_geometry(8'(phase_cols[p]), 7'(phase_rows[p]));
      nc = (phase_cols[p] == 0) ? 1 : ((phase_cols[p] > 128) ? 128 : phase_cols[p]);
      nr = (phase_rows[p] == 0) ? 1 : ((phase_rows[p] > 64) ? 64 : phase_rows[p]);
      for (n = 0; n < phase_items[p]; n++) begin
        if (p == 0 && n == 60) hold_reqs <= hold_reqs + 1;
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(3) != 0)
            send_item(KIND_READ, 8'($urandom), 7'($urandom_range(nc - 1)),
                      6'($urandom_range(nr - 1)));
          else
            send_item(KIND_READ, 8'($urandom), 7'($urandom), 6'($urandom));
        end else begin
          pick = $urandom_range(99);
          if (pick < 6) ch = CH_LF;
          else if (pick < 9) ch = CH_CR;
          else if (pick < 17) ch = CH_BS;
          else if (pick < 18) ch = CH_FF;
          else ch = 8'($urandom);
          send_item(KIND_PUT, ch, 7'($urandom), 6'($urandom));
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### text_console_cursor_scroll.f
hw/rtl/tccs_pkg.sv
hw/rtl/tccs_ram.sv
hw/rtl/tccs_ctrl.sv
hw/rtl/text_console_cursor_scroll.sv
verif/tccs_checker.sv
verif/tb_text_console_cursor_scroll.sv
